>>> hdl/nrm_pkg.sv
// nrm_pkg: shared types and constants for the nearest resolution match unit
// used by the controller, the datapath and the top level; depends on nothing

package nrm_pkg;

   // fixed field widths
   localparam int COUNT_BITS    = 5;
   localparam int INDEX_BITS    = 4;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // item kinds carried in tuser on the request side
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_ENTRY_COUNT      = 3'd0;
   localparam logic [2:0] REG_MIN_WIDTH        = 3'd1;
   localparam logic [2:0] REG_MAX_WIDTH        = 3'd2;
   localparam logic [2:0] REG_WIDTH_INCREMENT  = 3'd3;
   localparam logic [2:0] REG_MIN_HEIGHT       = 3'd4;
   localparam logic [2:0] REG_MAX_HEIGHT       = 3'd5;
   localparam logic [2:0] REG_HEIGHT_INCREMENT = 3'd6;

   // controller to datapath commands
   typedef struct packed {
      logic wr_en;       // store the request word into the table
      logic latch_req;   // capture the query's requested size
      logic issue;       // read one table entry into the distance pipe
      logic first;       // the issued entry is entry zero
      logic div_start;   // start the remainder unit
      logic axis_h;      // quantize height instead of width
      logic take_quant;  // store the quantized value of the current axis
      logic load_out;    // load the output register
      logic sel_search;  // output comes from the table search
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pipe_busy;   // distance pipe still holds entries
      logic div_done;    // remainder ready this cycle
   } status_type;

endpackage

>>> hdl/nrm_divider.sv
// nrm_divider: restoring remainder unit, one quotient bit per cycle
// uses no package; instantiated by nrm_datapath

module nrm_divider #(
   parameter int WIDTH = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_BITS = $clog2(WIDTH);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]    dvd_ff, dvd_in;
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    div_ff, div_in;
   logic [WIDTH:0]      trial;
   logic [WIDTH:0]      trial_sub;

   assign trial     = {rem_ff, dvd_ff[WIDTH-1]};
   assign trial_sub = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits in WIDTH bits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial_sub[WIDTH-1:0];
         end else begin
            rem_in = trial[WIDTH-1:0];
         end
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("remainder done held longer than one cycle");

endmodule

>>> hdl/nrm_datapath.sv
// nrm_datapath: entry table, squared distance pipe, best tracker, quantizer, output register
// depends on nrm_pkg and nrm_divider

module nrm_datapath #(
   parameter int TABLE_DEPTH = 16,
   parameter int COORD_BITS  = 14,
   parameter int ADDR_BITS   = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  nrm_pkg::cmd_type               cmd,
   output nrm_pkg::status_type            status,
   input  logic [ADDR_BITS-1:0]           rd_addr,
   input  logic [nrm_pkg::INDEX_BITS-1:0] req_index,
   input  logic [COORD_BITS-1:0]          req_entry_w,
   input  logic [COORD_BITS-1:0]          req_entry_h,
   input  logic [COORD_BITS-1:0]          req_w,
   input  logic [COORD_BITS-1:0]          req_h,
   input  logic [COORD_BITS-1:0]          min_width,
   input  logic [COORD_BITS-1:0]          max_width,
   input  logic [COORD_BITS-1:0]          width_increment,
   input  logic [COORD_BITS-1:0]          min_height,
   input  logic [COORD_BITS-1:0]          max_height,
   input  logic [COORD_BITS-1:0]          height_increment,
   output logic [COORD_BITS-1:0]          out_w,
   output logic [COORD_BITS-1:0]          out_h
);
   import nrm_pkg::*;

   localparam int CB = COORD_BITS;

   // entry table: height in the upper half, width in the lower
   logic [2*CB-1:0] tbl_mem [TABLE_DEPTH];

   logic [CB-1:0]   req_w_ff, req_h_ff;

   // distance pipe
   logic            v1_ff, v2_ff, v3_ff;
   logic            f1_ff, f2_ff, f3_ff;
   logic [2*CB-1:0] rd_ff;
   logic [CB-1:0]   adw_ff, adh_ff;
   logic [CB-1:0]   w2_ff, h2_ff, w3_ff, h3_ff;
   logic [2*CB-1:0] sqw_ff, sqh_ff;
   logic [2*CB:0]   score;
   logic [2*CB:0]   best_ff;
   logic [CB-1:0]   bw_ff, bh_ff;
   logic [CB-1:0]   rd_w, rd_h;

   // quantizer
   logic [CB-1:0]   q_req, q_lo, q_hi, q_inc;
   logic            q_neg;
   logic [CB-1:0]   q_mag;
   logic [CB-1:0]   q_rem;
   logic            q_done;
   logic [CB-1:0]   q_val, q_clamped;
   logic [CB-1:0]   qw_ff, qh_ff;
   logic [CB-1:0]   out_w_ff, out_h_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (32'(req_index) < TABLE_DEPTH)) begin
         tbl_mem[ADDR_BITS'(req_index)] <= {req_entry_h, req_entry_w};
      end
      rd_ff <= tbl_mem[rd_addr];
   end

   assign rd_w  = rd_ff[CB-1:0];
   assign rd_h  = rd_ff[2*CB-1:CB];
   assign score = {1'b0, sqw_ff} + {1'b0, sqh_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (cmd.latch_req) begin
         req_w_ff <= req_w;
         req_h_ff <= req_h;
      end
      f1_ff  <= cmd.first;
      f2_ff  <= f1_ff;
      f3_ff  <= f2_ff;
      adw_ff <= (req_w_ff >= rd_w) ? req_w_ff - rd_w : rd_w - req_w_ff;
      adh_ff <= (req_h_ff >= rd_h) ? req_h_ff - rd_h : rd_h - req_h_ff;
      w2_ff  <= rd_w;
      h2_ff  <= rd_h;
      sqw_ff <= (2*CB)'(adw_ff) * (2*CB)'(adw_ff);
      sqh_ff <= (2*CB)'(adh_ff) * (2*CB)'(adh_ff);
      w3_ff  <= w2_ff;
      h3_ff  <= h2_ff;
      // strict less-than keeps the lowest index on a tie
      if (v3_ff && (f3_ff || (score < best_ff))) begin
         best_ff <= score;
         bw_ff   <= w3_ff;
         bh_ff   <= h3_ff;
      end
   end

   // one axis at a time through the shared remainder unit
   assign q_req = cmd.axis_h ? req_h_ff         : req_w_ff;
   assign q_lo  = cmd.axis_h ? min_height       : min_width;
   assign q_hi  = cmd.axis_h ? max_height       : max_width;
   assign q_inc = cmd.axis_h ? height_increment : width_increment;
   assign q_neg = q_req < q_lo;
   assign q_mag = q_neg ? q_lo - q_req : q_req - q_lo;

   nrm_divider #(
      .WIDTH(CB)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (q_mag),
      .divisor  (q_inc),
      .done     (q_done),
      .remainder(q_rem)
   );

   // truncation toward zero moves the request toward the minimum by the remainder
   assign q_val     = q_neg ? q_req + q_rem : q_req - q_rem;
   assign q_clamped = (q_val > q_hi) ? q_hi : q_val;

   always_ff @(posedge clock) begin
      if (cmd.take_quant) begin
         if (cmd.axis_h) begin
            qh_ff <= q_clamped;
         end else begin
            qw_ff <= q_clamped;
         end
      end
      if (cmd.load_out) begin
         out_w_ff <= cmd.sel_search ? bw_ff : qw_ff;
         out_h_ff <= cmd.sel_search ? bh_ff : qh_ff;
      end
   end

   assign status.pipe_busy = v1_ff | v2_ff | v3_ff;
   assign status.div_done  = q_done;
   assign out_w            = out_w_ff;
   assign out_h            = out_h_ff;

endmodule

>>> hdl/nrm_controller.sv
// nrm_controller: sequencer for table writes, table search and stepped quantization
// depends on nrm_pkg; drives the datapath through cmd_type and reads status_type

module nrm_controller #(
   parameter int TABLE_DEPTH = 16,
   parameter int ADDR_BITS   = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_mode,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [nrm_pkg::COUNT_BITS-1:0] entry_count,
   input  logic                           inc_ok,
   input  nrm_pkg::status_type            status,
   output nrm_pkg::cmd_type               cmd,
   output logic [ADDR_BITS-1:0]           rd_addr
);
   import nrm_pkg::*;

   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_STARTW = 3'd3;
   localparam logic [2:0] S_WAITW  = 3'd4;
   localparam logic [2:0] S_STARTH = 3'd5;
   localparam logic [2:0] S_WAITH  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                search_ff, search_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0] n_eff;
   logic                accept;

   // a count above the table depth searches the whole table
   always_comb begin
      if (32'(entry_count) > TABLE_DEPTH) begin
         n_eff = CNT_BITS'(TABLE_DEPTH);
      end else begin
         n_eff = CNT_BITS'(entry_count);
      end
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      search_in  = search_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (req_mode == MODE_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.latch_req = 1'b1;
                  if (entry_count != '0) begin
                     idx_in    = '0;
                     search_in = 1'b1;
                     state_in  = S_SEARCH;
                  end else if (inc_ok) begin
                     search_in = 1'b0;
                     state_in  = S_STARTW;
                  end
               end
            end
         end
         S_SEARCH: begin
            cmd.issue = 1'b1;
            cmd.first = (idx_ff == '0);
            idx_in    = idx_ff + CNT_BITS'(1);
            if (idx_in == n_eff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_STARTW: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAITW;
         end
         S_WAITW: begin
            if (status.div_done) begin
               cmd.take_quant = 1'b1;
               state_in       = S_STARTH;
            end
         end
         S_STARTH: begin
            cmd.axis_h    = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = S_WAITH;
         end
         S_WAITH: begin
            cmd.axis_h = 1'b1;
            if (status.div_done) begin
               cmd.take_quant = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out   = 1'b1;
               cmd.sel_search = search_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         search_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         search_ff    <= search_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rd_addr    = idx_ff[ADDR_BITS-1:0];
   assign rsp_tvalid = rsp_valid_ff;

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten while a word is pending");

   a_search_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (idx_ff < n_eff))
      else $error("search index past the entry count");

endmodule

>>> hdl/nearest_resolution_match_unit.sv
// nearest_resolution_match_unit: top level with the csr block and the two channels
// depends on nrm_pkg, nrm_controller, nrm_datapath (and through it nrm_divider)
//
// usage
//   req channel: one word per item. tuser is the mode: write stores a width and
//   height pair into a table slot and gives no result; query gives at most one
//   result word on the rsp channel.
//   query with entry_count nonzero: the table entries 0 .. count-1 are walked in
//   order and the first entry with the least squared distance is returned.
//   query with entry_count zero and both increments nonzero: each axis is snapped
//   to min + k*increment (truncated toward the minimum) and clamped to max.
//   any other query gives no result word.
//   a search reads one table entry per cycle into a four stage distance pipe;
//   stepped mode runs width and then height through the bit serial remainder
//   unit that is shared by the two axes. the next item is taken in the cycle
//   after the result is loaded, while that result still waits in the output
//   register.
//   reset clears the csr registers and the sequencer; table contents are not
//   cleared and must be written before they are searched.
//   a stalled rsp side holds the result word; a finished query then waits for
//   the output register to free up before it loads and goes back to idle.

module nearest_resolution_match_unit #(
   parameter int TABLE_DEPTH = 16,
   parameter int COORD_BITS  = 14
) (
   input  logic                                               clock,
   input  logic                                               reset,
   // req word
   input  logic                                               req_tvalid,
   output logic                                               req_tready,
   // tdata: entry_index, entry_width, entry_height, request_w, request_h, zero pad
   input  logic [((nrm_pkg::INDEX_BITS+4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: mode
   input  logic                                               req_tuser,
   // rsp word
   output logic                                               rsp_tvalid,
   input  logic                                               rsp_tready,
   // tdata: chosen_width, chosen_height, zero pad
   output logic [((2*COORD_BITS+7)/8)*8-1:0]                  rsp_tdata,
   // tuser: found
   output logic                                               rsp_tuser,
   // csr port
   input  logic                                               csr_psel,
   input  logic                                               csr_penable,
   input  logic                                               csr_pwrite,
   input  logic [nrm_pkg::CSR_ADDR_BITS-1:0]                  csr_paddr,
   input  logic [nrm_pkg::CSR_DATA_BITS-1:0]                  csr_pwdata,
   output logic [nrm_pkg::CSR_DATA_BITS-1:0]                  csr_prdata,
   output logic                                               csr_pready
);
   import nrm_pkg::*;

   localparam int CB        = COORD_BITS;
   localparam int RSP_BITS  = ((2*COORD_BITS+7)/8)*8;
   localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // field offsets inside req_tdata
   localparam int OFF_EW = INDEX_BITS;
   localparam int OFF_EH = OFF_EW + CB;
   localparam int OFF_RW = OFF_EH + CB;
   localparam int OFF_RH = OFF_RW + CB;

   logic [COUNT_BITS-1:0] entry_count_ff;
   logic [CB-1:0]         min_width_ff, max_width_ff, width_increment_ff;
   logic [CB-1:0]         min_height_ff, max_height_ff, height_increment_ff;
   logic                  csr_write;
   logic [2:0]            csr_index;

   cmd_type               cmd;
   status_type            status;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  inc_ok;
   logic [CB-1:0]         out_w, out_h;

   // csr block: always ready, write lands on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff      <= '0;
         min_width_ff        <= '0;
         max_width_ff        <= '0;
         width_increment_ff  <= '0;
         min_height_ff       <= '0;
         max_height_ff       <= '0;
         height_increment_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ENTRY_COUNT:      entry_count_ff      <= csr_pwdata[COUNT_BITS-1:0];
            REG_MIN_WIDTH:        min_width_ff        <= csr_pwdata[CB-1:0];
            REG_MAX_WIDTH:        max_width_ff        <= csr_pwdata[CB-1:0];
            REG_WIDTH_INCREMENT:  width_increment_ff  <= csr_pwdata[CB-1:0];
            REG_MIN_HEIGHT:       min_height_ff       <= csr_pwdata[CB-1:0];
            REG_MAX_HEIGHT:       max_height_ff       <= csr_pwdata[CB-1:0];
            REG_HEIGHT_INCREMENT: height_increment_ff <= csr_pwdata[CB-1:0];
            default: begin
            end
         endcase
      end
   end

   // read mux, unmapped register indexes read as zero
   always_comb begin
      case (csr_index)
         REG_ENTRY_COUNT:      csr_prdata = CSR_DATA_BITS'(entry_count_ff);
         REG_MIN_WIDTH:        csr_prdata = CSR_DATA_BITS'(min_width_ff);
         REG_MAX_WIDTH:        csr_prdata = CSR_DATA_BITS'(max_width_ff);
         REG_WIDTH_INCREMENT:  csr_prdata = CSR_DATA_BITS'(width_increment_ff);
         REG_MIN_HEIGHT:       csr_prdata = CSR_DATA_BITS'(min_height_ff);
         REG_MAX_HEIGHT:       csr_prdata = CSR_DATA_BITS'(max_height_ff);
         REG_HEIGHT_INCREMENT: csr_prdata = CSR_DATA_BITS'(height_increment_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // stepped mode needs a nonzero step on both axes
   assign inc_ok = (width_increment_ff != '0) && (height_increment_ff != '0);

   nrm_controller #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .ADDR_BITS  (ADDR_BITS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .entry_count(entry_count_ff),
      .inc_ok     (inc_ok),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   nrm_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rd_addr         (rd_addr),
      .req_index       (req_tdata[INDEX_BITS-1:0]),
      .req_entry_w     (req_tdata[OFF_EW +: CB]),
      .req_entry_h     (req_tdata[OFF_EH +: CB]),
      .req_w           (req_tdata[OFF_RW +: CB]),
      .req_h           (req_tdata[OFF_RH +: CB]),
      .min_width       (min_width_ff),
      .max_width       (max_width_ff),
      .width_increment (width_increment_ff),
      .min_height      (min_height_ff),
      .max_height      (max_height_ff),
      .height_increment(height_increment_ff),
      .out_w           (out_w),
      .out_h           (out_h)
   );

   // every word that goes out is a hit
   assign rsp_tdata = RSP_BITS'({out_h, out_w});
   assign rsp_tuser = 1'b1;

endmodule

>>> dv/tb_nearest_resolution_match_unit.sv
// tb_nearest_resolution_match_unit: self-checking bench for the resolution match unit,
// with a built-in table search and step quantizer as predictor and random idling on
// both channels; depends on nrm_pkg and nearest_resolution_match_unit
`timescale 1ns / 1ps

module tb_nearest_resolution_match_unit;
   import nrm_pkg::*;

   localparam int COORDS        = 14;
   localparam int DEPTH         = 16;
   localparam int REQ_BITS      = ((INDEX_BITS + 4 * COORDS + 7) / 8) * 8;
   localparam int RSP_BITS      = ((2 * COORDS + 7) / 8) * 8;
   localparam int COORD_MAX     = (1 << COORDS) - 1;
   // stepped mode is the slowest path; the settle wait adds margin on top of it
   localparam int SETTLE_CYCLES = 2 * COORDS + 12;
   localparam int PHASES        = 10;
   localparam int PHASE_WORDS   = 85;

   typedef logic [COORDS-1:0] coord_type;

   // one request word, unpacked
   typedef struct {
      logic                  mode;
      logic [INDEX_BITS-1:0] index;
      coord_type             entry_w;
      coord_type             entry_h;
      coord_type             want_w;
      coord_type             want_h;
   } res_request_type;

   // one predicted result word
   typedef struct {
      logic      found;
      coord_type width;
      coord_type height;
   } res_choice_type;

   typedef enum int { CFG_SEARCH, CFG_STEPPED, CFG_NONE } phase_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predictor state: a shadow of the table and of the csr block
   coord_type             shadow_w [DEPTH];
   coord_type             shadow_h [DEPTH];
   logic [COUNT_BITS-1:0] cfg_count;
   coord_type             cfg_min_w, cfg_max_w, cfg_inc_w;
   coord_type             cfg_min_h, cfg_max_h, cfg_inc_h;

   // results still owed by the block, oldest first
   res_choice_type pending_choices [$];

   int mismatches = 0;
   // idling odds in percent, changed per phase; zero means no idling at all
   int gap_pct    = 0;
   int stall_pct  = 0;

   nearest_resolution_match_unit #(
      .TABLE_DEPTH (DEPTH),
      .COORD_BITS  (COORDS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // step * trunc((req - base) / step) + base, capped at top, floored at zero;
   // signed division in sv truncates toward zero, so a request below the base
   // lands between the request and the base
   function automatic coord_type snap_to_step(coord_type req, coord_type base,
                                              coord_type top, coord_type step);
      longint diff;
      longint quot;
      longint snapped;
      diff    = longint'(req);
      diff    = diff - longint'(base);
      quot    = diff / longint'(step);
      snapped = quot * longint'(step) + longint'(base);
      if (snapped > longint'(top)) begin
         snapped = longint'(top);
      end
      if (snapped < 0) begin
         snapped = 0;
      end
      return coord_type'(snapped);
   endfunction

   // updates the shadow table for a write, or queues the answer of a query
   task automatic predict_request(input res_request_type rq);
      res_choice_type pick;
      longint         dw, dh, score, best;
      int             span;
      if (rq.mode == MODE_WRITE) begin
         shadow_w[rq.index] = rq.entry_w;
         shadow_h[rq.index] = rq.entry_h;
         return;
      end
      pick.found = 1'b1;
      if (cfg_count != 0) begin
         // count above the table depth just searches the whole table
         span = (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
         best = 0;
         for (int i = 0; i < span; i++) begin
            dw    = longint'(rq.want_w) - longint'(shadow_w[i]);
            dh    = longint'(rq.want_h) - longint'(shadow_h[i]);
            score = dw * dw + dh * dh;
            // strict compare: on a tie the lower index stays
            if (i == 0 || score < best) begin
               best        = score;
               pick.width  = shadow_w[i];
               pick.height = shadow_h[i];
            end
         end
         pending_choices.push_back(pick);
      end else if (cfg_inc_w != 0 && cfg_inc_h != 0) begin
         pick.width  = snap_to_step(rq.want_w, cfg_min_w, cfg_max_w, cfg_inc_w);
         pick.height = snap_to_step(rq.want_h, cfg_min_h, cfg_max_h, cfg_inc_h);
         pending_choices.push_back(pick);
      end
      // no table and no steps: nothing comes back
   endtask

   // ---------------------------------------------------------------------------
   // drivers, all called and returning at a falling edge
   // ---------------------------------------------------------------------------

   // tdata from bit 0 up: entry_index, entry_width, entry_height, request_w, request_h
   function automatic logic [REQ_BITS-1:0] pack_request(res_request_type rq);
      logic [REQ_BITS-1:0] word;
      word = '0;
      word[INDEX_BITS-1:0]                     = rq.index;
      word[INDEX_BITS +: COORDS]               = rq.entry_w;
      word[INDEX_BITS + COORDS +: COORDS]      = rq.entry_h;
      word[INDEX_BITS + 2 * COORDS +: COORDS]  = rq.want_w;
      word[INDEX_BITS + 3 * COORDS +: COORDS]  = rq.want_h;
      return word;
   endfunction

   // offers one request word, with an optional gap first, and predicts it on accept
   task automatic send_word(input res_request_type rq);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tdata  <= pack_request(rq);
      req_tuser  <= rq.mode;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_request(rq);
      @(negedge clock);
   endtask

   // stops sending and waits until every owed result is back, then lets any
   // write or unanswered query still in flight finish
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_choices.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // setup cycle, then access cycle; the register takes the value at the edge
   // where pready is seen high; an idle cycle follows
   task automatic csr_write(input logic [2:0] reg_idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (reg_idx)
         REG_ENTRY_COUNT:      cfg_count = value[COUNT_BITS-1:0];
         REG_MIN_WIDTH:        cfg_min_w = value[COORDS-1:0];
         REG_MAX_WIDTH:        cfg_max_w = value[COORDS-1:0];
         REG_WIDTH_INCREMENT:  cfg_inc_w = value[COORDS-1:0];
         REG_MIN_HEIGHT:       cfg_min_h = value[COORDS-1:0];
         REG_MAX_HEIGHT:       cfg_max_h = value[COORDS-1:0];
         REG_HEIGHT_INCREMENT: cfg_inc_h = value[COORDS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // all six step registers in one go
   task automatic set_steps(input coord_type min_w, input coord_type max_w,
                            input coord_type inc_w, input coord_type min_h,
                            input coord_type max_h, input coord_type inc_h);
      csr_write(REG_MIN_WIDTH, min_w);
      csr_write(REG_MAX_WIDTH, max_w);
      csr_write(REG_WIDTH_INCREMENT, inc_w);
      csr_write(REG_MIN_HEIGHT, min_h);
      csr_write(REG_MAX_HEIGHT, max_h);
      csr_write(REG_HEIGHT_INCREMENT, inc_h);
   endtask

   // full range most of the time, with a bias toward tiny values (ties) and
   // the ends of the range
   function automatic coord_type pick_coord();
      case ($urandom_range(0, 3))
         0, 1:    return coord_type'($urandom_range(0, COORD_MAX));
         2:       return coord_type'($urandom_range(0, 15));
         default: return ($urandom_range(0, 1) != 0)
                         ? coord_type'(COORD_MAX - $urandom_range(0, 1))
                         : coord_type'($urandom_range(0, 1));
      endcase
   endfunction

   function automatic res_request_type make_request(input logic mode, input coord_type w,
                                                    input coord_type h);
      res_request_type rq;
      rq.mode    = mode;
      rq.index   = INDEX_BITS'($urandom_range(0, DEPTH - 1));
      rq.entry_w = pick_coord();
      rq.entry_h = pick_coord();
      rq.want_w  = w;
      rq.want_h  = h;
      return rq;
   endfunction

   // table write with the other fields random
   task automatic store_entry(input int idx, input coord_type w, input coord_type h);
      res_request_type rq;
      rq         = make_request(MODE_WRITE, pick_coord(), pick_coord());
      rq.index   = INDEX_BITS'(idx);
      rq.entry_w = w;
      rq.entry_h = h;
      send_word(rq);
   endtask

   task automatic query(input coord_type w, input coord_type h);
      send_word(make_request(MODE_QUERY, w, h));
   endtask

   // ---------------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------------

   // rsp tdata from bit 0 up: chosen_width, chosen_height; tuser is found
   always @(posedge clock) begin : rsp_check
      res_choice_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_choices.size() == 0) begin
            $error("unexpected result word: found %0d width %0d height %0d",
                   rsp_tuser, rsp_tdata[COORDS-1:0], rsp_tdata[COORDS +: COORDS]);
            mismatches++;
         end else begin
            want = pending_choices.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[COORDS-1:0] !== want.width) begin
               $error("chosen_width: expected %0d, actual %0d",
                      want.width, rsp_tdata[COORDS-1:0]);
               mismatches++;
            end
            if (rsp_tdata[COORDS +: COORDS] !== want.height) begin
               $error("chosen_height: expected %0d, actual %0d",
                      want.height, rsp_tdata[COORDS +: COORDS]);
               mismatches++;
            end
         end
      end
   end

   // result side back-pressure: bursts of random length with ready low
   initial begin : rsp_stall
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            hold = $urandom_range(0, 5);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset state: no table, no steps, so queries give nothing back
   task automatic test_not_found();
      query(coord_type'(0), coord_type'(0));
      query(coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      drain_block();
   endtask

   // fills every slot, then checks corners, an exact hit, a tie and the count limits
   task automatic test_table_search();
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       store_entry(i, coord_type'(0), coord_type'(0));
            1:       store_entry(i, coord_type'(COORD_MAX), coord_type'(0));
            2:       store_entry(i, coord_type'(0), coord_type'(COORD_MAX));
            3:       store_entry(i, coord_type'(100), coord_type'(100));
            // same distance as slot 3 from (110, 100): slot 3 must win the tie
            9:       store_entry(i, coord_type'(120), coord_type'(100));
            15:      store_entry(i, coord_type'(COORD_MAX), coord_type'(COORD_MAX));
            default: store_entry(i, coord_type'(1000 * i + 37),
                                 coord_type'(COORD_MAX - 900 * i));
         endcase
      end
      drain_block();
      csr_write(REG_ENTRY_COUNT, DEPTH);
      query(coord_type'(0), coord_type'(0));
      query(coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      query(coord_type'(COORD_MAX), coord_type'(1));
      query(shadow_w[7], shadow_h[7]);
      query(coord_type'(110), coord_type'(100));
      drain_block();
      // count beyond the table depth searches all slots
      csr_write(REG_ENTRY_COUNT, (1 << COUNT_BITS) - 1);
      query(coord_type'(16000), coord_type'(COORD_MAX));
      drain_block();
      // only slot 0 searched
      csr_write(REG_ENTRY_COUNT, 1);
      query(coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      drain_block();
   endtask

   // stepped mode: request below the base, above the cap, and extreme settings
   task automatic test_stepped_snap();
      csr_write(REG_ENTRY_COUNT, 0);
      set_steps(coord_type'(100), coord_type'(1000), coord_type'(64),
                coord_type'(COORD_MAX), coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      query(coord_type'(50), coord_type'(0));
      query(coord_type'(0), coord_type'(8000));
      query(coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      drain_block();
      set_steps(coord_type'(0), coord_type'(COORD_MAX), coord_type'(1),
                coord_type'(COORD_MAX), coord_type'(0), coord_type'(COORD_MAX));
      query(coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      query(coord_type'(0), coord_type'(0));
      drain_block();
   endtask

   // phases of random words, each under its own register setting
   task automatic test_random_traffic();
      phase_kind_type  kind;
      res_request_type rq;
      int              write_pct;
      int              slot;
      coord_type       inc_w, inc_h;
      for (int p = 0; p < PHASES; p++) begin
         drain_block();
         kind = (p == 5) ? CFG_NONE : ((p % 2 == 0) ? CFG_SEARCH : CFG_STEPPED);
         // no idling in the last phase; elsewhere none, light or heavy
         if (p == PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = 20 * $urandom_range(0, 2);
            stall_pct = 20 * $urandom_range(0, 2);
         end
         case ($urandom_range(0, 3))
            0:       inc_w = coord_type'(1);
            1:       inc_w = coord_type'(COORD_MAX);
            2:       inc_w = coord_type'($urandom_range(1, 64));
            default: inc_w = coord_type'($urandom_range(1, COORD_MAX));
         endcase
         case ($urandom_range(0, 3))
            0:       inc_h = coord_type'(1);
            1:       inc_h = coord_type'(COORD_MAX);
            2:       inc_h = coord_type'($urandom_range(1, 64));
            default: inc_h = coord_type'($urandom_range(1, COORD_MAX));
         endcase
         case (kind)
            CFG_SEARCH: begin
               csr_write(REG_ENTRY_COUNT, ($urandom_range(0, 3) == 0) ? DEPTH
                                                                      : $urandom_range(1, 31));
               write_pct = 30;
            end
            CFG_STEPPED: begin
               csr_write(REG_ENTRY_COUNT, 0);
               write_pct = 10;
            end
            default: begin
               // one step of zero turns stepped mode off
               csr_write(REG_ENTRY_COUNT, 0);
               if ($urandom_range(0, 1) != 0) inc_w = '0;
               else inc_h = '0;
               write_pct = 20;
            end
         endcase
         set_steps(pick_coord(), pick_coord(), inc_w, pick_coord(), pick_coord(), inc_h);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 99) < write_pct) begin
               rq = make_request(MODE_WRITE, pick_coord(), pick_coord());
            end else begin
               rq = make_request(MODE_QUERY, pick_coord(), pick_coord());
               // aim close to a stored entry now and then
               if ($urandom_range(0, 3) == 0) begin
                  slot      = $urandom_range(0, DEPTH - 1);
                  rq.want_w = shadow_w[slot] ^ coord_type'($urandom_range(0, 3));
                  rq.want_h = shadow_h[slot] ^ coord_type'($urandom_range(0, 3));
               end
            end
            send_word(rq);
            // sender holds off until the block has answered everything
            if ($urandom_range(0, 63) == 0) begin
               drain_block();
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_WRITE;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_count   = '0;
      cfg_min_w   = '0;
      cfg_max_w   = '0;
      cfg_inc_w   = '0;
      cfg_min_h   = '0;
      cfg_max_h   = '0;
      cfg_inc_h   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_pct   = 20;
      stall_pct = 20;
      test_not_found();
      test_table_search();
      test_stepped_snap();
      test_random_traffic();
      drain_block();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
